// ===== rtl/core/frc_pkg.sv =====
// Shared types, codes and constants of the fragment reassembler.
// Used by every module under rtl/core but frc_ram; depends on nothing else.
`default_nettype none

package frc_pkg;

  // Defaults for the top-level parameters.
  localparam int FRAME_BYTES_DEF   = 1024;
  localparam int FRAG_DATA_MAX_DEF = 180;

  // Fixed layout of a fragment write: three 16-bit little-endian fields.
  localparam int HDR_BYTES = 6;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CHUNK_W        = 8;
  localparam int ADDR_W         = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
  localparam logic [10:0] MIN_LEN_RESET = 11'd16;
  localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

  // Request types.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_DROP  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Result kinds.
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_READ   = 1'b1;

  // Write status codes.
  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_COMPLETE   = 3'd1;
  localparam logic [2:0] ST_NOT_AUTH   = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd4;

  // Commands from the front to the back.
  localparam logic [1:0] CMD_EMIT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_COPY = 2'd2;
  localparam logic [1:0] CMD_CMP  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        byte_last;
    logic        authenticated;
    logic [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  status;
    logic [10:0] frame_length;
    logic [7:0]  read_byte;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               result_kind;
    logic [2:0]         status;
    logic [10:0]        frame_length;
    logic [ADDR_W-1:0]  addr;
    logic [CHUNK_W-1:0] chunk;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/frc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instantiated for the staging buffer and the frame store.
`default_nettype none

module frc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frc_cmd_fifo.sv =====
// Short command queue between the front and the back of the reassembler.
// Depends on frc_pkg for the command type.
`default_nettype none

module frc_cmd_fifo #(
  parameter int DEPTH = frc_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire frc_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output frc_pkg::cmd_t      pop_data
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  frc_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frc_front.sv =====
// Front of the reassembler: accepts requests, collects fragment headers,
// stages data bytes and judges each write. Depends on frc_pkg.
`default_nettype none

module frc_front #(
  parameter int FRAME_BYTES   = frc_pkg::FRAME_BYTES_DEF,
  parameter int FRAG_DATA_MAX = frc_pkg::FRAG_DATA_MAX_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire frc_pkg::in_item_t                         in_data,
  input  wire logic                                      cfg_we,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0]            cfg_wdata,
  output logic                                           cmd_valid,
  input  wire logic                                      cmd_ready,
  output frc_pkg::cmd_t                                  cmd_data,
  output logic                                           stg_we,
  output logic [((FRAG_DATA_MAX > 1) ? $clog2(FRAG_DATA_MAX) : 1)-1:0] stg_waddr,
  output logic [7:0]                                     stg_wdata,
  input  wire logic                                      sweep_done
);

  localparam int RC_W    = $clog2(FRAME_BYTES + 1);
  localparam int SA_W    = (FRAG_DATA_MAX > 1) ? $clog2(FRAG_DATA_MAX) : 1;
  localparam int WBC_MAX = frc_pkg::HDR_BYTES + FRAG_DATA_MAX + 1;
  localparam int WBC_W   = $clog2(WBC_MAX + 1);

  logic [15:0]      timeout_r, timeout_nxt;
  logic [10:0]      min_len_r, min_len_nxt;
  logic [RC_W-1:0]  exp_r, exp_nxt;
  logic [RC_W-1:0]  rc_r, rc_nxt;
  logic [16:0]      elapsed_r, elapsed_nxt;
  logic [WBC_W-1:0] wbc_r, wbc_nxt;
  logic             pend_r, pend_nxt;
  logic [15:0]      hdr_total_r, hdr_offset_r, hdr_chunk_r;
  logic [15:0]      hdr_total_cur, hdr_offset_cur, hdr_chunk_cur;

  logic             in_fire, is_wr, is_rd, is_tick, is_drop, judge;
  logic [WBC_W-1:0] wbc_inc, data_cnt;
  logic [16:0]      off_chunk;
  logic             len_bad, frame_bad, timed_out, first, total_bad;
  logic             dup, in_place, complete, chunk_zero, upd, do_copy;
  logic [RC_W-1:0]  exp_a, rc_a, exp_b, rc_b;
  frc_pkg::cmd_t    wr_cmd, rd_cmd;

  assign in_ready = cmd_ready && !pend_r;
  assign in_fire  = in_valid && in_ready;
  assign is_wr    = (in_data.req_type == frc_pkg::REQ_WRITE);
  assign is_tick  = (in_data.req_type == frc_pkg::REQ_TICK);
  assign is_drop  = (in_data.req_type == frc_pkg::REQ_DROP);
  assign is_rd    = (in_data.req_type == frc_pkg::REQ_READ);
  assign judge    = in_fire && is_wr && in_data.byte_last;

  // The byte count saturates one past the longest legal write.
  assign wbc_inc = (wbc_r == WBC_W'(WBC_MAX)) ? wbc_r : wbc_r + WBC_W'(1);

  always_comb begin
    hdr_total_cur  = hdr_total_r;
    hdr_offset_cur = hdr_offset_r;
    hdr_chunk_cur  = hdr_chunk_r;
    if (wbc_r < WBC_W'(frc_pkg::HDR_BYTES)) begin
      case (wbc_r[2:0])
        3'd0: hdr_total_cur[7:0]   = in_data.data_byte;
        3'd1: hdr_total_cur[15:8]  = in_data.data_byte;
        3'd2: hdr_offset_cur[7:0]  = in_data.data_byte;
        3'd3: hdr_offset_cur[15:8] = in_data.data_byte;
        3'd4: hdr_chunk_cur[7:0]   = in_data.data_byte;
        3'd5: hdr_chunk_cur[15:8]  = in_data.data_byte;
        default: ;
      endcase
    end
  end

  assign stg_we = in_fire && is_wr && (wbc_r >= WBC_W'(frc_pkg::HDR_BYTES)) &&
                  (wbc_r < WBC_W'(frc_pkg::HDR_BYTES + FRAG_DATA_MAX));
  assign stg_waddr = SA_W'(wbc_r - WBC_W'(frc_pkg::HDR_BYTES));
  assign stg_wdata = in_data.data_byte;

  // Judgment of a write at its last byte.
  assign data_cnt  = wbc_inc - WBC_W'(frc_pkg::HDR_BYTES);
  assign off_chunk = {1'b0, hdr_offset_cur} + {1'b0, hdr_chunk_cur};
  assign len_bad   = (wbc_inc < WBC_W'(frc_pkg::HDR_BYTES)) ||
                     (wbc_inc > WBC_W'(frc_pkg::HDR_BYTES + FRAG_DATA_MAX));
  assign frame_bad = (hdr_total_cur < 16'(min_len_r)) ||
                     ({1'b0, hdr_total_cur} > 17'(FRAME_BYTES)) ||
                     (hdr_chunk_cur != 16'(data_cnt)) ||
                     (off_chunk > {1'b0, hdr_total_cur});
  assign timed_out = (elapsed_r > {1'b0, timeout_r});
  assign exp_a     = timed_out ? '0 : exp_r;
  assign rc_a      = timed_out ? '0 : rc_r;
  assign first     = (hdr_offset_cur == 16'd0);
  assign exp_b     = first ? RC_W'(hdr_total_cur) : exp_a;
  assign rc_b      = first ? '0 : rc_a;
  assign total_bad = (hdr_total_cur != 16'(exp_b));
  assign dup       = ({1'b0, hdr_offset_cur} < 17'(rc_b)) && (off_chunk <= 17'(rc_b));
  assign in_place  = ({1'b0, hdr_offset_cur} == 17'(rc_b));
  assign complete  = (off_chunk == 17'(exp_b));
  assign chunk_zero = (hdr_chunk_cur == 16'd0);

  always_comb begin
    wr_cmd              = '0;
    wr_cmd.kind         = frc_pkg::CMD_EMIT;
    wr_cmd.result_kind  = frc_pkg::RK_STATUS;
    wr_cmd.status       = frc_pkg::ST_ACCEPTED;
    wr_cmd.addr         = hdr_offset_cur;
    wr_cmd.chunk        = frc_pkg::CHUNK_W'(hdr_chunk_cur);
    upd                 = 1'b0;
    do_copy             = 1'b0;
    if (!in_data.authenticated) begin
      wr_cmd.status = frc_pkg::ST_NOT_AUTH;
    end else if (len_bad || frame_bad) begin
      wr_cmd.status = frc_pkg::ST_BAD_LENGTH;
    end else begin
      upd = 1'b1;
      if (total_bad) begin
        wr_cmd.status = frc_pkg::ST_BAD_OFFSET;
      end else if (dup) begin
        // A repeat of received bytes: unless the chunk is empty, the back compares and decides the status.
        if (!chunk_zero) begin
          wr_cmd.kind = frc_pkg::CMD_CMP;
        end
      end else if (!in_place) begin
        wr_cmd.status = frc_pkg::ST_BAD_OFFSET;
      end else begin
        do_copy = 1'b1;
        if (!chunk_zero) begin
          wr_cmd.kind = frc_pkg::CMD_COPY;
        end
        if (complete) begin
          wr_cmd.status       = frc_pkg::ST_COMPLETE;
          wr_cmd.frame_length = 11'(exp_b);
        end
      end
    end
  end

  always_comb begin
    rd_cmd             = '0;
    rd_cmd.kind        = ({7'd0, in_data.read_index} < 17'(FRAME_BYTES)) ?
                         frc_pkg::CMD_READ : frc_pkg::CMD_EMIT;
    rd_cmd.result_kind = frc_pkg::RK_READ;
    rd_cmd.status      = frc_pkg::ST_ACCEPTED;
    rd_cmd.addr        = frc_pkg::ADDR_W'(in_data.read_index);
  end

  assign cmd_valid = in_fire && (is_rd || (is_wr && in_data.byte_last));
  assign cmd_data  = is_rd ? rd_cmd : wr_cmd;

  always_comb begin
    timeout_nxt = timeout_r;
    min_len_nxt = min_len_r;
    exp_nxt     = exp_r;
    rc_nxt      = rc_r;
    elapsed_nxt = elapsed_r;
    wbc_nxt     = wbc_r;
    pend_nxt    = pend_r;
    if (cfg_we) begin
      case (cfg_index)
        frc_pkg::CFG_TIMEOUT: timeout_nxt = cfg_wdata;
        frc_pkg::CFG_MIN_LEN: min_len_nxt = 11'(cfg_wdata);
        default: ;
      endcase
    end
    if (sweep_done) begin
      pend_nxt = 1'b0;
    end
    if (in_fire && is_tick && (elapsed_r != frc_pkg::ELAPSED_MAX)) begin
      elapsed_nxt = elapsed_r + 17'd1;
    end
    if (in_fire && is_drop) begin
      exp_nxt = '0;
      rc_nxt  = '0;
      wbc_nxt = '0;
    end
    if (in_fire && is_wr) begin
      wbc_nxt = in_data.byte_last ? '0 : wbc_inc;
    end
    if (judge && upd) begin
      exp_nxt = exp_b;
      rc_nxt  = rc_b;
      if (first) begin
        elapsed_nxt = '0;
      end
      if (do_copy) begin
        if (complete) begin
          exp_nxt = '0;
          rc_nxt  = '0;
        end else begin
          rc_nxt = RC_W'(off_chunk);
        end
      end
    end
    if (cmd_valid && ((cmd_data.kind == frc_pkg::CMD_COPY) ||
                      (cmd_data.kind == frc_pkg::CMD_CMP))) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= frc_pkg::TIMEOUT_RESET;
      min_len_r <= frc_pkg::MIN_LEN_RESET;
      exp_r     <= '0;
      rc_r      <= '0;
      elapsed_r <= frc_pkg::ELAPSED_MAX;
      wbc_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      timeout_r <= timeout_nxt;
      min_len_r <= min_len_nxt;
      exp_r     <= exp_nxt;
      rc_r      <= rc_nxt;
      elapsed_r <= elapsed_nxt;
      wbc_r     <= wbc_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Header bytes are always rewritten before a write of full length uses them.
  always_ff @(posedge clk) begin
    if (in_fire && is_wr) begin
      hdr_total_r  <= hdr_total_cur;
      hdr_offset_r <= hdr_offset_cur;
      hdr_chunk_r  <= hdr_chunk_cur;
    end
  end

  a_done_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_done |-> pend_r)
    else $error("sweep finished with no sweep outstanding");

  a_rc_within_total: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= exp_r)
    else $error("received count beyond expected total");

  a_total_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    17'(exp_r) <= 17'(FRAME_BYTES))
    else $error("expected total larger than the frame store");

endmodule

`default_nettype wire

// ===== rtl/core/frc_back.sv =====
// Back of the reassembler: executes queued commands against the frame store,
// copies or compares staged fragments and registers results. Depends on frc_pkg.
`default_nettype none

module frc_back #(
  parameter int FRAME_BYTES   = frc_pkg::FRAME_BYTES_DEF,
  parameter int FRAG_DATA_MAX = frc_pkg::FRAG_DATA_MAX_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      cmd_valid,
  output logic                                           cmd_ready,
  input  wire frc_pkg::cmd_t                             cmd_data,
  output logic                                           stg_re,
  output logic [((FRAG_DATA_MAX > 1) ? $clog2(FRAG_DATA_MAX) : 1)-1:0] stg_raddr,
  input  wire logic [7:0]                                stg_rdata,
  output logic                                           fr_we,
  output logic [$clog2(FRAME_BYTES)-1:0]                 fr_waddr,
  output logic [7:0]                                     fr_wdata,
  output logic                                           fr_re,
  output logic [$clog2(FRAME_BYTES)-1:0]                 fr_raddr,
  input  wire logic [7:0]                                fr_rdata,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output frc_pkg::out_item_t                             out_data,
  output logic                                           sweep_done
);

  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int SA_W = (FRAG_DATA_MAX > 1) ? $clog2(FRAG_DATA_MAX) : 1;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                         state_r, state_nxt;
  frc_pkg::cmd_t                cmd_r;
  logic [frc_pkg::CHUNK_W-1:0]  sw_idx_r, sw_idx_nxt;
  logic                         pv_r;
  logic [FA_W-1:0]              pfa_r;
  logic                         mism_r, mism_nxt;
  logic                         s1_v_r, s1_v_nxt;
  logic                         s1_ram_r;
  frc_pkg::out_item_t           s1_item_r;
  logic                         out_v_r, out_v_nxt;
  frc_pkg::out_item_t           out_r;

  logic                         out_load, s1_move, s1_free, pop, pop_sweep;
  logic                         issue, sweep_fin, is_cmp;
  logic [FA_W-1:0]              fa_issue;
  frc_pkg::out_item_t           pop_item, fin_item, s1_out;

  assign out_load  = !out_v_r || out_ready;
  assign s1_move   = s1_v_r && out_load;
  assign s1_free   = !s1_v_r || out_load;
  assign cmd_ready = (state_r == ST_RUN) && s1_free;
  assign pop       = cmd_valid && cmd_ready;
  assign pop_sweep = pop && ((cmd_data.kind == frc_pkg::CMD_COPY) ||
                             (cmd_data.kind == frc_pkg::CMD_CMP));

  assign is_cmp    = (cmd_r.kind == frc_pkg::CMD_CMP);
  assign issue     = (state_r == ST_SWEEP) && (sw_idx_r < cmd_r.chunk);
  assign sweep_fin = (state_r == ST_SWEEP) && !issue && !pv_r;
  assign sweep_done = sweep_fin;
  assign fa_issue  = FA_W'(cmd_r.addr + frc_pkg::ADDR_W'(sw_idx_r));

  // One staged byte is fetched per cycle; its store or compare follows in the next cycle.
  assign stg_re    = issue;
  assign stg_raddr = SA_W'(sw_idx_r);
  assign fr_re     = (pop && (cmd_data.kind == frc_pkg::CMD_READ)) || (issue && is_cmp);
  assign fr_raddr  = (state_r == ST_SWEEP) ? fa_issue : FA_W'(cmd_data.addr);
  assign fr_we     = pv_r && !is_cmp;
  assign fr_waddr  = pfa_r;
  assign fr_wdata  = stg_rdata;

  always_comb begin
    pop_item              = '0;
    pop_item.result_kind  = cmd_data.result_kind;
    pop_item.status       = cmd_data.status;
    pop_item.frame_length = cmd_data.frame_length;

    fin_item              = '0;
    fin_item.result_kind  = frc_pkg::RK_STATUS;
    if (is_cmp) begin
      fin_item.status = mism_r ? frc_pkg::ST_BAD_OFFSET : frc_pkg::ST_ACCEPTED;
    end else begin
      fin_item.status       = cmd_r.status;
      fin_item.frame_length = cmd_r.frame_length;
    end

    s1_out           = s1_item_r;
    s1_out.read_byte = s1_ram_r ? fr_rdata : 8'd0;
  end

  always_comb begin
    state_nxt  = state_r;
    sw_idx_nxt = sw_idx_r;
    mism_nxt   = mism_r;
    s1_v_nxt   = s1_v_r;
    out_v_nxt  = out_v_r;

    if (pop_sweep) begin
      state_nxt  = ST_SWEEP;
      sw_idx_nxt = '0;
      mism_nxt   = 1'b0;
    end else if (sweep_fin) begin
      state_nxt = ST_RUN;
    end
    if (issue) begin
      sw_idx_nxt = sw_idx_r + frc_pkg::CHUNK_W'(1);
    end
    if (pv_r && is_cmp && (stg_rdata != fr_rdata)) begin
      mism_nxt = 1'b1;
    end

    if (pop && !pop_sweep) begin
      s1_v_nxt = 1'b1;
    end else if (sweep_fin) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end

    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      sw_idx_r <= '0;
      pv_r     <= 1'b0;
      mism_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sw_idx_r <= sw_idx_nxt;
      pv_r     <= issue;
      mism_r   <= mism_nxt;
      s1_v_r   <= s1_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pfa_r <= fa_issue;
    if (pop) begin
      cmd_r     <= cmd_data;
      s1_item_r <= pop_item;
      s1_ram_r  <= (cmd_data.kind == frc_pkg::CMD_READ);
    end else if (sweep_fin) begin
      s1_item_r <= fin_item;
      s1_ram_r  <= 1'b0;
    end
    if (s1_move) begin
      out_r <= s1_out;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    fr_we |-> (state_r == ST_SWEEP))
    else $error("frame store written outside a copy sweep");

  a_stage_empty_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !s1_v_r)
    else $error("result stage occupied while the frame store read port is swept");

  a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (sw_idx_r <= cmd_r.chunk))
    else $error("sweep index ran past the fragment length");

endmodule

`default_nettype wire

// ===== rtl/core/fragment_reassembler_core.sv =====
// Fragment reassembler. A read request's result passes the command queue, the result
// stage and the output register. Throughput is one request per cycle while the queue
// has room and no sweep is pending; a write carrying data to be stored or compared
// holds the input while the back sweeps the staging buffer one byte per cycle
// through the frame store. Reset is synchronous and clears all control state; the
// frame store is not cleared, and requests are taken in the first cycle after reset.
`default_nettype none

module fragment_reassembler_core #(
  parameter int FRAME_BYTES   = frc_pkg::FRAME_BYTES_DEF,
  parameter int FRAG_DATA_MAX = frc_pkg::FRAG_DATA_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire frc_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output frc_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int SA_W = (FRAG_DATA_MAX > 1) ? $clog2(FRAG_DATA_MAX) : 1;

  logic            fq_valid, fq_ready, bq_valid, bq_ready;
  frc_pkg::cmd_t   fq_data, bq_data;
  logic            stg_we, stg_re;
  logic [SA_W-1:0] stg_waddr, stg_raddr;
  logic [7:0]      stg_wdata, stg_rdata;
  logic            fr_we, fr_re;
  logic [FA_W-1:0] fr_waddr, fr_raddr;
  logic [7:0]      fr_wdata, fr_rdata;
  logic            sweep_done;

  frc_front #(
    .FRAME_BYTES  (FRAME_BYTES),
    .FRAG_DATA_MAX(FRAG_DATA_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data),
    .stg_we    (stg_we),
    .stg_waddr (stg_waddr),
    .stg_wdata (stg_wdata),
    .sweep_done(sweep_done)
  );

  frc_cmd_fifo #(
    .DEPTH(frc_pkg::CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_data),
    .pop_valid (bq_valid),
    .pop_ready (bq_ready),
    .pop_data  (bq_data)
  );

  frc_ram #(
    .WIDTH(8),
    .DEPTH(FRAG_DATA_MAX)
  ) u_stage_ram (
    .clk  (clk),
    .we   (stg_we),
    .waddr(stg_waddr),
    .wdata(stg_wdata),
    .re   (stg_re),
    .raddr(stg_raddr),
    .rdata(stg_rdata)
  );

  frc_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (fr_we),
    .waddr(fr_waddr),
    .wdata(fr_wdata),
    .re   (fr_re),
    .raddr(fr_raddr),
    .rdata(fr_rdata)
  );

  frc_back #(
    .FRAME_BYTES  (FRAME_BYTES),
    .FRAG_DATA_MAX(FRAG_DATA_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bq_valid),
    .cmd_ready (bq_ready),
    .cmd_data  (bq_data),
    .stg_re    (stg_re),
    .stg_raddr (stg_raddr),
    .stg_rdata (stg_rdata),
    .fr_we     (fr_we),
    .fr_waddr  (fr_waddr),
    .fr_wdata  (fr_wdata),
    .fr_re     (fr_re),
    .fr_raddr  (fr_raddr),
    .fr_rdata  (fr_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .sweep_done(sweep_done)
  );

endmodule

`default_nettype wire
